### sv/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Shared constants for the signed square root lane block.
// ----------------------------------------------------------------------------
`default_nettype none
package sss_pkg;
  localparam int LANE_COUNT = 8;
  localparam int NUM_STEPS  = 24;
  localparam int PIPE_DEPTH = NUM_STEPS + 1;

  localparam logic [31:0] MAG_MASK   = 32'h7FFF_FFFF;
  localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
  localparam logic [31:0] EXP_ALL    = 32'h7F80_0000;
  localparam logic [31:0] QUIET_BIT  = 32'h0040_0000;
  localparam logic [31:0] HIDDEN_BIT = 32'h0080_0000;
endpackage
`default_nettype wire

### sv/sss_lane.sv
// ----------------------------------------------------------------------------
// sss_lane
// One lane: decode, 24 pipelined root steps, round and sign restore.
// ----------------------------------------------------------------------------
`default_nettype none
module sss_lane
  import sss_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] x_i,
  output logic [31:0]      y_o
);
  logic [47:0] n_q   [NUM_STEPS+1];
  logic [47:0] res_q [NUM_STEPS+1];
  logic [7:0]  exp_q [NUM_STEPS+1];
  logic        spec_q[NUM_STEPS+1];
  logic        sign_q[NUM_STEPS+1];
  logic [31:0] sval_q[NUM_STEPS+1];

  // decode
  logic [31:0] a;
  logic [22:0] frac;
  logic [4:0]  lead;
  logic [24:0] sig;
  logic signed [9:0] e, unb;
  logic [31:0] sval_d;
  logic        spec_d;
  logic [7:0]  exp_d;

  always_comb begin
    a    = x_i & MAG_MASK;
    frac = a[22:0];
    lead = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (frac[i]) lead = 5'(i);
    end
    if (a[30:23] == 8'd0) begin
      sig = 25'({frac, 1'b0} << (5'd22 - lead));
      e   = 10'sd1 - $signed({5'd0, 5'd23 - lead});
    end else begin
      sig = {2'b01, frac};
      e   = $signed({2'b00, a[30:23]});
    end
    unb = e - 10'sd127;
    if (unb[0]) begin
      sig = sig << 1;
      unb = unb - 10'sd1;
    end
    exp_d  = 8'((unb >>> 1) + 10'sd127);
    spec_d = (a == 32'd0) || (a >= EXP_ALL);
    sval_d = (a > EXP_ALL) ? (x_i | QUIET_BIT) : x_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]    <= {sig[24:0], 23'd0};
      res_q[0]  <= 48'd0;
      exp_q[0]  <= exp_d;
      spec_q[0] <= spec_d;
      sign_q[0] <= x_i[31];
      sval_q[0] <= sval_d;
    end
  end

  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
    localparam logic [47:0] BIT = 48'd1 << (46 - 2 * k);
    logic [47:0] sum, n_d, r_d;
    always_comb begin
      sum = res_q[k] + BIT;
      if (n_q[k] >= sum) begin
        n_d = n_q[k] - sum;
        r_d = (res_q[k] >> 1) + BIT;
      end else begin
        n_d = n_q[k];
        r_d = res_q[k] >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k+1]    <= n_d;
        res_q[k+1]  <= r_d;
        exp_q[k+1]  <= exp_q[k];
        spec_q[k+1] <= spec_q[k];
        sign_q[k+1] <= sign_q[k];
        sval_q[k+1] <= sval_q[k];
      end
    end
  end

  // round to nearest, a tie cannot occur
  logic [31:0] bits;
  always_comb begin
    bits = {1'b0, exp_q[NUM_STEPS], 23'd0} + res_q[NUM_STEPS][31:0] - HIDDEN_BIT;
    if (n_q[NUM_STEPS] > res_q[NUM_STEPS]) bits = bits + 32'd1;
    y_o = spec_q[NUM_STEPS] ? sval_q[NUM_STEPS] : {sign_q[NUM_STEPS], bits[30:0]};
  end
endmodule
`default_nettype wire

### sv/signed_sqrt_float_lanes.sv
// ----------------------------------------------------------------------------
// signed_sqrt_float_lanes
// Eight lanes of correctly rounded single-precision square root, sign kept.
// ----------------------------------------------------------------------------
// a request passes the decode register, each root step register and the output register
// throughput: one item per cycle while the pipe is not held, set by one root step per pipeline stage
// the whole pipe holds while the output register is full and not taken
// reset clears the valid bits only; no clearing pass
`default_nettype none
module signed_sqrt_float_lanes
  import sss_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] in_lane0_i,
  input  wire logic [31:0] in_lane1_i,
  input  wire logic [31:0] in_lane2_i,
  input  wire logic [31:0] in_lane3_i,
  input  wire logic [31:0] in_lane4_i,
  input  wire logic [31:0] in_lane5_i,
  input  wire logic [31:0] in_lane6_i,
  input  wire logic [31:0] in_lane7_i,
  input  wire logic [3:0]  lanes_valid_i,
  input  wire logic        in_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      out_lane0_o,
  output logic [31:0]      out_lane1_o,
  output logic [31:0]      out_lane2_o,
  output logic [31:0]      out_lane3_o,
  output logic [31:0]      out_lane4_o,
  output logic [31:0]      out_lane5_o,
  output logic [31:0]      out_lane6_o,
  output logic [31:0]      out_lane7_o,
  output logic [3:0]       lanes_written_o,
  output logic             out_last_o
);
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic [31:0] x [8];
  logic [31:0] y [8];
  assign x = '{in_lane0_i, in_lane1_i, in_lane2_i, in_lane3_i,
               in_lane4_i, in_lane5_i, in_lane6_i, in_lane7_i};

  for (genvar l = 0; l < 8; l++) begin : g_lane
    sss_lane u_lane (.clk_i(clk_i), .en_i(en), .x_i(x[l]), .y_o(y[l]));
  end

  logic [3:0] cnt_d;
  assign cnt_d = (lanes_valid_i > 4'(LANE_COUNT)) ? 4'(LANE_COUNT) : lanes_valid_i;

  logic       vld_q [PIPE_DEPTH];
  logic [3:0] cnt_q [PIPE_DEPTH];
  logic       last_q[PIPE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_DEPTH; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < PIPE_DEPTH; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cnt_q[0]  <= cnt_d;
      last_q[0] <= in_last_i;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        cnt_q[i]  <= cnt_q[i-1];
        last_q[i] <= last_q[i-1];
      end
    end
  end

  // merge: mask lanes at or beyond the count into the output register
  logic [31:0] m [8];
  always_comb begin
    for (int l = 0; l < 8; l++) begin
      m[l] = (4'(l) < cnt_q[PIPE_DEPTH-1]) ? y[l] : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vld_q[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_lane0_o     <= m[0];
      out_lane1_o     <= m[1];
      out_lane2_o     <= m[2];
      out_lane3_o     <= m[3];
      out_lane4_o     <= m[4];
      out_lane5_o     <= m[5];
      out_lane6_o     <= m[6];
      out_lane7_o     <= m[7];
      lanes_written_o <= cnt_q[PIPE_DEPTH-1];
      out_last_o      <= last_q[PIPE_DEPTH-1];
    end
  end

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lanes_written_o <= 4'(LANE_COUNT))
    else $error("lanes_written above lane count");
  a_tail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && lanes_written_o < 4'd8) |-> out_lane7_o == 32'd0)
    else $error("lane beyond count not zero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_lane0_o)))
    else $error("stalled result changed");
endmodule
`default_nettype wire
